// ===== sv/rhc_pkg.sv =====
// Shared types, constants and the division step function of the RGB to HSV converter.
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int CHAN_W          = 8;
	localparam int HUE_W           = 16;
	localparam int SAT_W           = 16;
	localparam int FRACTION_BITS   = 16;
	// Six times the largest chroma is 1530, which needs eleven bits.
	localparam int NUM_W           = 11;
	localparam int BITS_PER_STAGE  = 4;
	localparam int DIV_STAGES      = (FRACTION_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	// Front stage, setup stage, division stages and the output register.
	localparam int NUM_STAGES      = DIV_STAGES + 3;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  saturation;
		logic [CHAN_W-1:0] brightness;
		logic              hue_defined;
	} hsv_t;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] max_val;
		logic [CHAN_W-1:0] min_val;
		max_sel_t          max_sel;
	} prep_t;

	typedef struct packed {
		logic [NUM_W-1:0]         hue_rem;
		logic [NUM_W-1:0]         hue_div;
		logic [FRACTION_BITS-1:0] hue_q;
		logic [CHAN_W-1:0]        sat_rem;
		logic [CHAN_W-1:0]        sat_div;
		logic [FRACTION_BITS-1:0] sat_q;
		logic [CHAN_W-1:0]        brightness;
		logic                     grey;
		logic                     black;
		logic                     full;
	} div_t;

	// Up to BITS_PER_STAGE restoring division steps for both quotients.
	// Quotient bit first_bit + i is produced only while it lies inside the fraction.
	function automatic div_t div_step(input div_t x, input int unsigned first_bit);
		div_t              y;
		logic [NUM_W:0]    ht;
		logic [CHAN_W:0]   st;
		logic              hb;
		logic              sb;
		y = x;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			if (first_bit + i < FRACTION_BITS) begin
				ht = {y.hue_rem, 1'b0};
				hb = (ht >= {1'b0, y.hue_div});
				if (hb) begin
					y.hue_rem = NUM_W'(ht - {1'b0, y.hue_div});
				end else begin
					y.hue_rem = NUM_W'(ht);
				end
				y.hue_q = {y.hue_q[FRACTION_BITS-2:0], hb};

				st = {y.sat_rem, 1'b0};
				sb = (st >= {1'b0, y.sat_div});
				if (sb) begin
					y.sat_rem = CHAN_W'(st - {1'b0, y.sat_div});
				end else begin
					y.sat_rem = CHAN_W'(st);
				end
				y.sat_q = {y.sat_q[FRACTION_BITS-2:0], sb};
			end
		end
		return y;
	endfunction

endpackage

// ===== sv/rgb_to_hsv_converter.sv =====
// Top level of the pipelined RGB to HSV converter.
`timescale 1ns / 1ps

// Channel   Direction   Payload                                   Handshake
// pixel     in          red, green, blue (8 bits each)            pixel_valid / pixel_ready
// hsv       out         hue, saturation, brightness, hue_defined  hsv_valid / hsv_ready
//
// One pixel is taken per clock cycle while pixel_ready is high. Each result passes through
// the stages (at 16 fraction bits): one stage finds the largest and smallest channel,
// one forms chroma, the hue numerator and the divisors, four stages run the long division
// at four quotient bits each, and one stage formats the result into the output register.
// Reset clears only the valid bit of each stage; the data registers are left as they are.
// When hsv_ready is low the output register holds its result, bubbles in the stages behind
// it close up, and only when every stage is full does pixel_ready drop.
module rgb_to_hsv_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pixel_valid,
	output logic          pixel_ready,
	input  rhc_pkg::pixel_t pixel,
	output logic          hsv_valid,
	input  logic          hsv_ready,
	output rhc_pkg::hsv_t hsv
);
	import rhc_pkg::*;

	localparam int LAST = NUM_STAGES - 1;

	logic [NUM_STAGES-1:0] valid_sn;
	logic [NUM_STAGES-1:0] rdy;

	prep_t prep_s1;
	div_t  div_s2;
	div_t  iter_sn [DIV_STAGES];
	hsv_t  hsv_s_last;

	prep_t prep_nxt;
	div_t  setup_nxt;
	hsv_t  fmt_nxt;

	// A stage may load when it is empty or when the stage after it is loading too.
	always_comb begin
		rdy[LAST] = !valid_sn[LAST] || hsv_ready;
		for (int k = LAST - 1; k >= 0; k--) begin
			rdy[k] = !valid_sn[k] || rdy[k+1];
		end
	end

	assign pixel_ready = rdy[0];
	assign hsv_valid   = valid_sn[LAST];
	assign hsv         = hsv_s_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= '0;
		end else begin
			if (rdy[0]) begin
				valid_sn[0] <= pixel_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_sn[k] <= valid_sn[k-1];
				end
			end
		end
	end

	// Stage 1: largest and smallest channel. Ties go to red, then to green.
	always_comb begin
		prep_nxt.red   = pixel.red;
		prep_nxt.green = pixel.green;
		prep_nxt.blue  = pixel.blue;
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			prep_nxt.max_sel = SEL_RED;
			prep_nxt.max_val = pixel.red;
		end else if (pixel.green >= pixel.blue) begin
			prep_nxt.max_sel = SEL_GREEN;
			prep_nxt.max_val = pixel.green;
		end else begin
			prep_nxt.max_sel = SEL_BLUE;
			prep_nxt.max_val = pixel.blue;
		end
		if (pixel.red <= pixel.green && pixel.red <= pixel.blue) begin
			prep_nxt.min_val = pixel.red;
		end else if (pixel.green <= pixel.blue) begin
			prep_nxt.min_val = pixel.green;
		end else begin
			prep_nxt.min_val = pixel.blue;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			prep_s1 <= prep_nxt;
		end
	end

	// Stage 2: chroma, hue numerator base*d + num and the two divisors. For nonzero d the
	// numerator is below 6*d and d is at most the largest channel, so neither remainder starts above its divisor.
	always_comb begin
		logic [CHAN_W-1:0] d;
		logic [NUM_W-1:0]  d2;
		logic [NUM_W-1:0]  d4;
		d  = prep_s1.max_val - prep_s1.min_val;
		d2 = NUM_W'({d, 1'b0});
		d4 = NUM_W'({d, 2'b00});

		case (prep_s1.max_sel)
			SEL_RED: begin
				if (prep_s1.green >= prep_s1.blue) begin
					setup_nxt.hue_rem = NUM_W'(prep_s1.green - prep_s1.blue);
				end else begin
					setup_nxt.hue_rem = d4 + d2 - NUM_W'(prep_s1.blue - prep_s1.green);
				end
			end
			SEL_GREEN: begin
				setup_nxt.hue_rem = d2 + NUM_W'(prep_s1.blue) - NUM_W'(prep_s1.red);
			end
			default: begin
				setup_nxt.hue_rem = d4 + NUM_W'(prep_s1.red) - NUM_W'(prep_s1.green);
			end
		endcase

		setup_nxt.hue_div    = d4 + d2;
		setup_nxt.hue_q      = '0;
		setup_nxt.sat_rem    = d;
		setup_nxt.sat_div    = prep_s1.max_val;
		setup_nxt.sat_q      = '0;
		setup_nxt.brightness = prep_s1.max_val;
		setup_nxt.grey       = (d == '0);
		setup_nxt.black      = (prep_s1.max_val == '0);
		setup_nxt.full       = (d == prep_s1.max_val);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			div_s2 <= setup_nxt;
		end
	end

	// Division stages: each produces the next few quotient bits of hue and saturation.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		div_t stage_in;

		if (k == 0) begin : g_first
			assign stage_in = div_s2;
		end else begin : g_rest
			assign stage_in = iter_sn[k-1];
		end

		always_ff @(posedge clk) begin
			if (rdy[k+2]) begin
				iter_sn[k] <= div_step(stage_in, k * BITS_PER_STAGE);
			end
		end
	end

	// Output formatting. A black pixel has no division for saturation, and full chroma
	// would give one whole unit, which saturates to all ones.
	always_comb begin
		div_t last;
		last = iter_sn[DIV_STAGES-1];
		fmt_nxt.hue         = last.grey ? '0 : HUE_W'(last.hue_q);
		if (last.black) begin
			fmt_nxt.saturation = '0;
		end else if (last.full) begin
			fmt_nxt.saturation = SAT_W'({FRACTION_BITS{1'b1}});
		end else begin
			fmt_nxt.saturation = SAT_W'(last.sat_q);
		end
		fmt_nxt.brightness  = last.brightness;
		fmt_nxt.hue_defined = !last.grey;
	end

	always_ff @(posedge clk) begin
		if (rdy[LAST]) begin
			hsv_s_last <= fmt_nxt;
		end
	end

endmodule

// ===== sv/rhc_checker.sv =====
// Port checker for the RGB to HSV converter and its bind to the top level.
`timescale 1ns / 1ps

module rhc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            pixel_ready,
	input logic            hsv_valid,
	input logic            hsv_ready,
	input rhc_pkg::hsv_t   hsv
);
	import rhc_pkg::*;

	// A stalled result must stay in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_ready |=> hsv_valid && $stable(hsv))
		else $error("result changed or vanished while stalled");

	// A grey pixel carries neither hue nor saturation.
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv.hue_defined |-> hsv.hue == '0 && hsv.saturation == '0)
		else $error("grey result with nonzero hue or saturation");

	// A black pixel is grey.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.brightness == '0 |-> !hsv.hue_defined)
		else $error("black result marked with a hue");

	// Nonzero chroma never gives zero saturation.
	a_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.hue_defined |-> hsv.saturation != '0)
		else $error("coloured result with zero saturation");

	// Pixels are refused only while a result waits at a stalled output.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> hsv_valid && !hsv_ready)
		else $error("pixel refused while the output is free");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);

// ===== bench/tb_rgb_to_hsv_converter.sv =====
// Self-checking testbench for the RGB to HSV converter, with a scoreboard class and a predictor.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter;

	import rhc_pkg::*;

	// The number of random pixels after the directed ones.
	localparam int RANDOM_PIXELS = 1200;
	// The limit lies well above the slowest correct run: 1223 pixels, each with the largest idle
	// gap at the source, the largest stall at the sink and the seven pipeline stages, plus two
	// long hold-offs.
	localparam int CYCLE_LIMIT = 200000;
	// Cycles allowed after the last result for anything stray to come out.
	localparam int DRAIN_CYCLES = 20;
	// Length of the deliberate back-pressure stretches, well beyond the pipeline depth.
	localparam int LONG_HOLD = 64;

	// The scoreboard keeps the expected results in order of their input transfers and
	// compares every output transfer with the oldest of them.
	class hsv_scoreboard;
		hsv_t   pending_hsv[$];
		pixel_t pending_pixel[$];
		int     errors;
		int     results;

		function new();
			errors  = 0;
			results = 0;
		endfunction

		// Bit-exact prediction: value is the largest channel, saturation is chroma over
		// value as a 16-bit fraction, and hue is a fraction of a turn taken from the
		// sector of the largest channel. All quotients are truncated.
		function hsv_t predict_hsv(pixel_t p);
			longint unsigned r;
			longint unsigned g;
			longint unsigned b;
			longint unsigned hi;
			longint unsigned lo;
			longint unsigned chroma;
			longint unsigned numer;
			longint unsigned sat;
			longint unsigned hue;
			hsv_t            res;
			r = p.red;
			g = p.green;
			b = p.blue;
			hi = (r > g) ? r : g;
			hi = (hi > b) ? hi : b;
			lo = (r < g) ? r : g;
			lo = (lo < b) ? lo : b;
			chroma = hi - lo;
			sat = 0;
			hue = 0;
			if (hi != 0) begin
				sat = (chroma << FRACTION_BITS) / hi;
				if (sat > (64'd1 << FRACTION_BITS) - 1) begin
					sat = (64'd1 << FRACTION_BITS) - 1;
				end
			end
			if (chroma != 0) begin
				// Red wins ties over green, and green over blue.
				if (hi == r) begin
					numer = (g >= b) ? g - b : 6 * chroma - (b - g);
				end else if (hi == g) begin
					numer = 2 * chroma + b - r;
				end else begin
					numer = 4 * chroma + r - g;
				end
				hue = (numer << FRACTION_BITS) / (6 * chroma);
			end
			res.hue         = HUE_W'(hue);
			res.saturation  = SAT_W'(sat);
			res.brightness  = CHAN_W'(hi);
			res.hue_defined = (chroma != 0);
			return res;
		endfunction

		function void note_pixel(pixel_t p);
			pending_pixel = {pending_pixel, p};
			pending_hsv   = {pending_hsv, predict_hsv(p)};
		endfunction

		function int outstanding();
			return pending_hsv.size();
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_hsv(hsv_t got);
			hsv_t   want;
			pixel_t src;
			string  tag;
			if (pending_hsv.size() == 0) begin
				report_mismatch($sformatf(
					"result with nothing expected: hue=%0d sat=%0d val=%0d def=%0b",
					got.hue, got.saturation, got.brightness, got.hue_defined));
			end else begin
				want = pending_hsv.pop_front();
				src  = pending_pixel.pop_front();
				tag  = $sformatf("result %0d rgb=(%0d,%0d,%0d)",
					results, src.red, src.green, src.blue);
				if (got.hue !== want.hue) begin
					report_mismatch($sformatf("%s hue %0d, expected %0d",
						tag, got.hue, want.hue));
				end
				if (got.saturation !== want.saturation) begin
					report_mismatch($sformatf("%s saturation %0d, expected %0d",
						tag, got.saturation, want.saturation));
				end
				if (got.brightness !== want.brightness) begin
					report_mismatch($sformatf("%s brightness %0d, expected %0d",
						tag, got.brightness, want.brightness));
				end
				if (got.hue_defined !== want.hue_defined) begin
					report_mismatch($sformatf("%s hue_defined %0b, expected %0b",
						tag, got.hue_defined, want.hue_defined));
				end
			end
			results++;
		endtask
	endclass

	logic   clk;
	logic   arst_n;
	logic   pixel_valid;
	logic   pixel_ready;
	pixel_t pixel;
	logic   hsv_valid;
	logic   hsv_ready;
	hsv_t   hsv;

	hsv_scoreboard sb;
	int            pixels_sent;
	int            cycle_count;

	rgb_to_hsv_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hsv        (hsv)
	);

	// A 4 ns clock period.
	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	// The watchdog ends a run that hangs, for instance because a transfer never happens.
	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic pixel_t make_pixel(int r, int g, int b);
		pixel_t p;
		p.red   = CHAN_W'(r);
		p.green = CHAN_W'(g);
		p.blue  = CHAN_W'(b);
		return p;
	endfunction

	// Random pixels are weighted towards the awkward corners: grey pixels, ties for the
	// largest channel, channels at or next to the ends of their range, and tiny chroma.
	// The remainder are entirely random.
	function automatic pixel_t random_pixel();
		int v;
		int o;
		pixel_t p;
		case ($urandom_range(0, 9))
			0: begin
				v = $urandom_range(0, 255);
				p = make_pixel(v, v, v);
			end
			1: begin
				v = $urandom_range(1, 255);
				o = $urandom_range(0, v - 1);
				case ($urandom_range(0, 2))
					0: p = make_pixel(v, v, o);
					1: p = make_pixel(v, o, v);
					default: p = make_pixel(o, v, v);
				endcase
			end
			2: begin
				p.red   = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 1)) :
					CHAN_W'($urandom_range(254, 255));
				p.green = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 1)) :
					CHAN_W'($urandom_range(254, 255));
				p.blue  = $urandom_range(0, 1) ? CHAN_W'($urandom_range(0, 1)) :
					CHAN_W'($urandom_range(254, 255));
			end
			3: begin
				v = $urandom_range(1, 254);
				p = make_pixel(v - 1 + $urandom_range(0, 2), v - 1 + $urandom_range(0, 2),
					v - 1 + $urandom_range(0, 2));
			end
			default: begin
				p = make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			end
		endcase
		return p;
	endfunction

	// Offers one pixel and returns once its transfer has happened. The idle gap comes first;
	// valid is only lowered when there is a gap, so back-to-back pixels keep it high.
	// Two stretches of the random part run with no gaps at all.
	task automatic send_pixel(pixel_t p);
		int gap;
		if ((pixels_sent >= 300 && pixels_sent < 450) ||
			(pixels_sent >= 900 && pixels_sent < 1000)) begin
			gap = 0;
		end else begin
			gap = $urandom_range(0, 8);
		end
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		// Sampled just after the rising edge, before the block's registers update.
		do @(posedge clk); while (!pixel_ready);
		sb.note_pixel(p);
		pixels_sent++;
	endtask

	// The result sink. It draws a stall before each result, runs two stretches without
	// stalls, and twice holds ready low for a long stretch so that the pipeline fills up
	// and the block has to refuse pixels.
	initial begin : hsv_sink
		int stall;
		hsv_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sb.results == 100 || sb.results == 700) begin
				stall = LONG_HOLD;
			end else if ((sb.results >= 250 && sb.results < 400) ||
				(sb.results >= 1000 && sb.results < 1100)) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 8);
			end
			@(negedge clk);
			if (stall > 0) begin
				hsv_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			hsv_ready <= 1'b1;
			do @(posedge clk); while (!hsv_valid);
			sb.check_hsv(hsv);
		end
	end

	initial begin : pixel_source
		sb          = new();
		pixels_sent = 0;
		pixel_valid = 1'b0;
		pixel       = '0;
		arst_n      = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pixels: black, white and a mid grey (no hue), the primaries and
		// secondaries, ties for the maximum in every pairing, red as maximum with blue
		// above green (the hue wraps near a full turn), chroma of one, and full chroma.
		send_pixel(make_pixel(0, 0, 0));
		send_pixel(make_pixel(255, 255, 255));
		send_pixel(make_pixel(128, 128, 128));
		send_pixel(make_pixel(255, 0, 0));
		send_pixel(make_pixel(0, 255, 0));
		send_pixel(make_pixel(0, 0, 255));
		send_pixel(make_pixel(255, 255, 0));
		send_pixel(make_pixel(0, 255, 255));
		send_pixel(make_pixel(255, 0, 255));
		send_pixel(make_pixel(255, 0, 1));
		send_pixel(make_pixel(255, 1, 0));
		send_pixel(make_pixel(0, 255, 1));
		send_pixel(make_pixel(1, 255, 0));
		send_pixel(make_pixel(1, 0, 255));
		send_pixel(make_pixel(0, 1, 255));
		send_pixel(make_pixel(1, 0, 0));
		send_pixel(make_pixel(255, 254, 254));
		send_pixel(make_pixel(254, 255, 255));
		send_pixel(make_pixel(200, 0, 100));
		send_pixel(make_pixel(1, 1, 0));
		send_pixel(make_pixel(2, 1, 1));
		send_pixel(make_pixel(85, 170, 90));
		send_pixel(make_pixel(170, 85, 170));

		repeat (RANDOM_PIXELS) send_pixel(random_pixel());

		@(negedge clk);
		pixel_valid <= 1'b0;

		// Wait for every expected result, then give stray results a chance to show up.
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
		end

		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
